[hdl/euclidean_path_length_accumulator_defines.svh]
// assertion macros for the path length accumulator
`ifndef EUCLIDEAN_PATH_LENGTH_ACCUMULATOR_DEFINES_SVH
`define EUCLIDEAN_PATH_LENGTH_ACCUMULATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EPLACC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eplacc check failed");

// antecedent implies consequent in the next cycle
`define EPLACC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eplacc check failed");

`endif

[hdl/eplacc_pkg.sv]
package eplacc_pkg;

	localparam int IN_W    = 16;
	localparam int STEP_W  = 25;
	localparam int TOTAL_W = 40;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[hdl/eplacc_sqr.sv]
module eplacc_sqr
	import eplacc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [COORD_BITS-1:0]   ax,
	input  logic [COORD_BITS-1:0]   ay,
	output logic [2*COORD_BITS:0]   sum,
	output unit_stat_t              stat
);

	localparam int SW = 2 * COORD_BITS + 1;
	localparam int CW = $clog2(COORD_BITS);
	localparam logic [CW-1:0] LAST = CW'(COORD_BITS - 1);

	logic [SW-1:0]         ma_q, mb_q, acc_q;
	logic [COORD_BITS-1:0] xa_q, xb_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;
	logic [SW-1:0]         pa, pb;

	assign pa = xa_q[0] ? ma_q : '0;
	assign pb = xb_q[0] ? mb_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			done_q <= (cnt_q == LAST);
			if (cnt_q == LAST)
				busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// one multiplier bit per cycle for both squares
	always_ff @(posedge clk) begin
		if (go) begin
			ma_q  <= SW'(ax);
			mb_q  <= SW'(ay);
			xa_q  <= ax;
			xb_q  <= ay;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pa + pb;
			ma_q  <= ma_q << 1;
			mb_q  <= mb_q << 1;
			xa_q  <= xa_q >> 1;
			xb_q  <= xb_q >> 1;
		end
	end

	assign sum       = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[hdl/eplacc_sqrt.sv]
module eplacc_sqrt
	import eplacc_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [2*COORD_BITS:0]             d2,
	output logic [COORD_BITS+FRAC_BITS:0]     root,
	output unit_stat_t                        stat
);

	localparam int P  = COORD_BITS + 1 + FRAC_BITS;
	localparam int RW = 2 * P;
	localparam int CW = $clog2(P);
	localparam logic [CW-1:0] LAST = CW'(P - 1);

	logic [RW-1:0]  rad_q;
	logic [P-1:0]   rem_q, root_q;
	logic [P+1:0]   rem_sh, trial, diff, rem_nx;
	logic           ge;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;

	// one root bit per cycle from the top radicand pair
	assign rem_sh = {rem_q, rad_q[RW-1:RW-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign diff   = rem_sh - trial;
	assign rem_nx = ge ? diff : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			done_q <= (cnt_q == LAST);
			if (cnt_q == LAST)
				busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= RW'(d2) << (2 * FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_nx[P-1:0];
			root_q <= {root_q[P-2:0], ge};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[hdl/euclidean_path_length_accumulator.sv]
// euclidean path length accumulator
// input channel (in_valid/in_ready): one beat carries new_x, new_y and
// start_req. a start beat, or the first beat after reset, sets the position
// and clears the total; every other beat is a move from the stored position.
// output channel (out_valid/out_ready): one beat per input beat with
// step_length, total_length and total_saturated, 8 fraction bits.
// a move is squared one multiplier bit per cycle, then square-rooted one root
// bit per cycle, then added to the saturating total once the output register
// is free; a start beat goes from ST_IDLE straight to ST_ACC.
// a new beat is taken in the cycle after the result is registered, so only
// one beat is in flight at a time.
// the result sits in an output register; a stalled receiver holds it there
// while the next beat is computed, and the block waits only when it must
// load a second result over an unread one.
// reset clears the position, the total and the saturation flag; the next
// beat is then treated as a start.
module euclidean_path_length_accumulator
	import eplacc_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8,
	parameter int TOTAL_BITS = 40
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [IN_W-1:0]    new_x,
	input  logic signed [IN_W-1:0]    new_y,
	input  logic                      start_req,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STEP_W-1:0]         step_length,
	output logic [TOTAL_W-1:0]        total_length,
	output logic                      total_saturated
);

	localparam int C  = COORD_BITS;
	localparam int P  = C + 1 + FRAC_BITS;
	localparam int SW = 2 * C + 1;
	localparam int XW = (P > STEP_W) ? P : STEP_W;
	localparam int AW = ((TOTAL_BITS > P) ? TOTAL_BITS : P) + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SQR  = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_ACC  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [C-1:0]          cx_q, cy_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic                  known_q, sat_q, start_q;
	logic                  out_valid_q;
	logic [STEP_W-1:0]     step_q;
	logic [TOTAL_W-1:0]    total_out_q;
	logic                  sat_out_q;

	logic [63:0]           x_ext, y_ext;
	logic [C-1:0]          xc, yc, ax, ay;
	logic signed [C:0]     dx, dy;
	logic [C:0]            ndx, ndy;
	logic                  accept, is_start, out_free;
	logic                  sqr_go, sqrt_go;
	logic [SW-1:0]         d2;
	logic [P-1:0]          root;
	unit_stat_t            sqr_stat, sqrt_stat;

	logic [AW-1:0]         sum_w;
	logic                  sat_hit;
	logic [TOTAL_BITS-1:0] total_nx;
	logic                  sat_nx;
	logic [XW-1:0]         step_x;
	logic [STEP_W-1:0]     step_nx;
	logic [63:0]           total_w;

	assign x_ext = 64'($unsigned(new_x));
	assign y_ext = 64'($unsigned(new_y));
	assign xc    = x_ext[C-1:0];
	assign yc    = y_ext[C-1:0];

	assign dx  = $signed({xc[C-1], xc}) - $signed({cx_q[C-1], cx_q});
	assign dy  = $signed({yc[C-1], yc}) - $signed({cy_q[C-1], cy_q});
	assign ndx = -dx;
	assign ndy = -dy;
	assign ax  = dx[C] ? ndx[C-1:0] : dx[C-1:0];
	assign ay  = dy[C] ? ndy[C-1:0] : dy[C-1:0];

	assign in_ready = (state_q == ST_IDLE) && !sqr_stat.busy && !sqrt_stat.busy;
	assign accept   = in_valid && in_ready;
	assign is_start = start_req || !known_q;
	assign out_free = !out_valid_q || out_ready;
	assign sqr_go   = accept && !is_start;
	assign sqrt_go  = (state_q == ST_SQR) && sqr_stat.done;

	eplacc_sqr #(
		.COORD_BITS(C)
	) u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sqr_go),
		.ax     (ax),
		.ay     (ay),
		.sum    (d2),
		.stat   (sqr_stat)
	);

	eplacc_sqrt #(
		.COORD_BITS(C),
		.FRAC_BITS (FRAC_BITS)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sqrt_go),
		.d2     (d2),
		.root   (root),
		.stat   (sqrt_stat)
	);

	// saturating accumulate
	assign sum_w    = AW'(total_q) + AW'(root);
	assign sat_hit  = |sum_w[AW-1:TOTAL_BITS];
	assign total_nx = start_q ? '0 : (sat_hit ? '1 : sum_w[TOTAL_BITS-1:0]);
	assign sat_nx   = start_q ? 1'b0 : (sat_q || sat_hit);
	assign step_x   = start_q ? '0 : XW'(root);
	assign step_nx  = (step_x > XW'(STEP_MAX)) ? STEP_MAX : step_x[STEP_W-1:0];
	assign total_w  = 64'(total_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cx_q        <= '0;
			cy_q        <= '0;
			total_q     <= '0;
			known_q     <= 1'b0;
			sat_q       <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ACC && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						known_q <= 1'b1;
						cx_q    <= xc;
						cy_q    <= yc;
						start_q <= is_start;
						state_q <= is_start ? ST_ACC : ST_SQR;
					end
				end
				ST_SQR: begin
					if (sqr_stat.done)
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sqrt_stat.done)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (out_free) begin
						total_q     <= total_nx;
						sat_q       <= sat_nx;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && out_free) begin
			step_q      <= step_nx;
			total_out_q <= total_w[TOTAL_W-1:0];
			sat_out_q   <= sat_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign step_length     = step_q;
	assign total_length    = total_out_q;
	assign total_saturated = sat_out_q;

endmodule

[hdl/eplacc_checker.sv]
`include "euclidean_path_length_accumulator_defines.svh"

module eplacc_checker
	import eplacc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [STEP_W-1:0]    step_length,
	input logic [TOTAL_W-1:0]   total_length,
	input logic                 total_saturated
);

	`EPLACC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(step_length) && $stable(total_length) && $stable(total_saturated))
	`EPLACC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	`EPLACC_ASSERT_NOW(a_sat_nonzero, out_valid && total_saturated, total_length != '0)

endmodule

bind euclidean_path_length_accumulator eplacc_checker u_eplacc_checker (.*);
